>>> sv/radix_digit_converter_assert.svh
// Assertion macros shared by the radix digit converter RTL.
`ifndef RADIX_DIGIT_CONVERTER_ASSERT_SVH
`define RADIX_DIGIT_CONVERTER_ASSERT_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define RDC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every clock edge outside reset.
`define RDC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/rdc_pkg.sv
// Package with types and constants of the radix digit converter.
`default_nettype none

package rdc_pkg;

    localparam int RDC_MAX_DIGITS = 31;
    localparam int RDC_MAX_BASE   = 16;

    localparam logic [15:0] SRC_BASE  = 16'd10;
    localparam logic [15:0] MIN_BASE  = 16'd2;
    localparam logic [63:0] PACK_CAP  = 64'd9999999999999999999;

    localparam int VALUE_W     = 32;
    localparam int DIV_BITS    = 8;
    localparam int DIV_STEPS   = VALUE_W / DIV_BITS;
    localparam int DIV_STEPS_W = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_FROM = 2'd1,
        ST_BAD_TO   = 2'd2,
        ST_NONPOS   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [15:0]        from_base;
        logic [15:0]        to_base;
        logic signed [31:0] value;
    } t_in;

    typedef struct packed {
        logic [3:0]  digit;
        logic        last;
        t_status     status;
        logic [63:0] packed_value;
        logic        packed_overflow;
    } t_out;

endpackage

`default_nettype wire

>>> sv/radix_digit_converter.sv
// Top level of the radix digit converter: shared divider, digit stack and packer.
//
// Usage: drive i_item and raise start; the item is taken at a clock edge where
// start is high and busy is low. Each result appears on o_result for exactly
// one cycle with o_valid high; the receiver cannot hold results off.
// A valid item is divided by the target base on one shared divider that
// resolves 8 quotient bits per cycle; digits go onto a stack and are then
// emitted most significant first, one per cycle, with the running decimal
// packed value updated by one 68-bit add and compare. Busy stays high
// through division and emission, and the first result shows only after
// the last digit is divided. Base 2 gives the most digits (31).
// An invalid item gives a single error result in the next cycle and does not
// raise busy, so a new item may follow at once.
// Reset clears the sequencer and the strobe; no item is in flight after reset.
`default_nettype none

module radix_digit_converter #(
    parameter int MAX_DIGITS = rdc_pkg::RDC_MAX_DIGITS,
    parameter int MAX_BASE   = rdc_pkg::RDC_MAX_BASE
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         start,
    output      logic         busy,
    input  wire rdc_pkg::t_in i_item,
    output      logic         o_valid,
    output rdc_pkg::t_out     o_result
);

    localparam int W_D = (MAX_BASE > 2) ? $clog2(MAX_BASE) : 1;
    localparam int W_B = $clog2(MAX_BASE + 1);
    localparam int W_N = $clog2(MAX_DIGITS + 1);

    rdc_pkg::t_state                r_state, n_state;
    logic [rdc_pkg::DIV_STEPS_W-1:0] r_step, n_step;
    logic [W_N-1:0]                 r_cnt, n_cnt;
    logic [31:0]                    r_div, n_div;
    logic [W_D-1:0]                 r_rem, n_rem;
    logic [W_B-1:0]                 r_base, n_base;
    logic [63:0]                    r_packed, n_packed;
    logic                           r_ovf, n_ovf;
    logic                           r_valid, n_valid;
    rdc_pkg::t_out                  r_out, n_out;
    logic [W_D-1:0]                 r_stk [MAX_DIGITS];

    logic [31:0]    div_q;
    logic [W_D-1:0] div_r;
    logic           push;
    logic           pop;
    logic [67:0]    pack_sum;

    // Shared divider slice: DIV_BITS restoring steps on the narrow remainder.
    always_comb begin
        logic [W_D:0] trial;
        div_q = r_div;
        div_r = r_rem;
        for (int i = 0; i < rdc_pkg::DIV_BITS; i++) begin
            trial = {div_r, div_q[31]};
            div_q = {div_q[30:0], 1'b0};
            if (trial >= (W_D + 1)'(r_base)) begin
                div_r    = W_D'(trial - (W_D + 1)'(r_base));
                div_q[0] = 1'b1;
            end else begin
                div_r = W_D'(trial);
            end
        end
    end

    assign pack_sum = {1'b0, r_packed, 3'b000} + {3'b000, r_packed, 1'b0}
                      + 68'(r_stk[0]);

    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        n_cnt    = r_cnt;
        n_div    = r_div;
        n_rem    = r_rem;
        n_base   = r_base;
        n_packed = r_packed;
        n_ovf    = r_ovf;
        n_valid  = 1'b0;
        n_out    = r_out;
        push     = 1'b0;
        pop      = 1'b0;
        unique case (r_state)
            rdc_pkg::S_IDLE: begin
                if (start) begin
                    n_out.digit           = 4'd0;
                    n_out.last            = 1'b1;
                    n_out.packed_value    = 64'd0;
                    n_out.packed_overflow = 1'b0;
                    n_out.status          = rdc_pkg::ST_OK;
                    if (i_item.from_base != rdc_pkg::SRC_BASE) begin
                        n_out.status = rdc_pkg::ST_BAD_FROM;
                    end else if (i_item.to_base < rdc_pkg::MIN_BASE
                                 || i_item.to_base > 16'(MAX_BASE)) begin
                        n_out.status = rdc_pkg::ST_BAD_TO;
                    end else if (i_item.value[31] || i_item.value == 32'sd0) begin
                        n_out.status = rdc_pkg::ST_NONPOS;
                    end
                    if (n_out.status != rdc_pkg::ST_OK) begin
                        n_valid = 1'b1;
                    end else begin
                        n_state = rdc_pkg::S_DIV;
                        n_div   = i_item.value;
                        n_rem   = '0;
                        n_step  = '0;
                        n_cnt   = '0;
                        n_base  = W_B'(i_item.to_base);
                    end
                end
            end
            rdc_pkg::S_DIV: begin
                n_div  = div_q;
                n_rem  = div_r;
                n_step = r_step + 1'b1;
                if (r_step == (rdc_pkg::DIV_STEPS_W)'(rdc_pkg::DIV_STEPS - 1)) begin
                    push  = 1'b1;
                    n_cnt = r_cnt + 1'b1;
                    n_rem = '0;
                    if (div_q == 32'd0 || r_cnt == W_N'(MAX_DIGITS - 1)) begin
                        n_state  = rdc_pkg::S_EMIT;
                        n_packed = 64'd0;
                        n_ovf    = 1'b0;
                    end
                end
            end
            rdc_pkg::S_EMIT: begin
                pop = 1'b1;
                if (!r_ovf) begin
                    if (pack_sum > {4'd0, rdc_pkg::PACK_CAP}) begin
                        n_ovf    = 1'b1;
                        n_packed = rdc_pkg::PACK_CAP;
                    end else begin
                        n_packed = pack_sum[63:0];
                    end
                end
                n_valid               = 1'b1;
                n_out.digit           = 4'(r_stk[0]);
                n_out.last            = (r_cnt == W_N'(1));
                n_out.status          = rdc_pkg::ST_OK;
                n_out.packed_value    = n_packed;
                n_out.packed_overflow = n_ovf;
                n_cnt                 = r_cnt - 1'b1;
                if (r_cnt == W_N'(1)) begin
                    n_state = rdc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rdc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rdc_pkg::S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step   <= n_step;
        r_cnt    <= n_cnt;
        r_div    <= n_div;
        r_rem    <= n_rem;
        r_base   <= n_base;
        r_packed <= n_packed;
        r_ovf    <= n_ovf;
        r_out    <= n_out;
    end

    // Digit stack: the newest digit sits on top and leaves first.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_stk[0] <= div_r;
            for (int i = 1; i < MAX_DIGITS; i++) begin
                r_stk[i] <= r_stk[i-1];
            end
        end else if (pop) begin
            for (int i = 0; i < MAX_DIGITS - 1; i++) begin
                r_stk[i] <= r_stk[i+1];
            end
        end
    end

    assign busy     = (r_state != rdc_pkg::S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_out;

`include "radix_digit_converter_assert.svh"

    `RDC_ASSERT_NOW(a_err_single, o_valid && o_result.status != rdc_pkg::ST_OK,
        o_result.last && o_result.packed_value == 64'd0 && !o_result.packed_overflow,
        "Error item result is not a single cleared result.")
    `RDC_ASSERT_NOW(a_div_depth, r_state == rdc_pkg::S_DIV, r_cnt < W_N'(MAX_DIGITS),
        "Digit count exceeds stack depth during division.")
    `RDC_ASSERT_NEXT(a_ovf_sticky, o_valid && o_result.packed_overflow && !o_result.last,
        o_valid && o_result.packed_overflow
        && o_result.packed_value == rdc_pkg::PACK_CAP,
        "Packed overflow flag dropped within an item.")
    `RDC_ASSERT_NEXT(a_emit_run, o_valid && !o_result.last,
        o_valid && busy == !o_result.last,
        "Digit results of one item are not contiguous.")

endmodule

`default_nettype wire

>>> tb/tb_radix_digit_converter.sv
// Self-checking testbench for the radix digit converter, with directed and random items.
module tb_radix_digit_converter;
    timeunit 1ns;
    timeprecision 1ps;

    import rdc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 200;
    localparam int DIR_ROWS    = 24;

    typedef struct packed {
        t_in  item;
        logic typed;
        t_out want;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_in  i_item;
    logic o_valid;
    t_out o_result;

    t_out pending_digits[$];
    int   mismatches = 0;
    int   cycle_count = 0;

    t_dir_row dir_rows [0:DIR_ROWS-1] = '{
        '{'{16'd0,     16'd2,     32'sd5},          1'b1, '{4'd0,  1'b1, ST_BAD_FROM, 64'd0,  1'b0}},
        '{'{16'hFFFF,  16'hFFFF,  -32'sd1},         1'b1, '{4'd0,  1'b1, ST_BAD_FROM, 64'd0,  1'b0}},
        '{'{16'd11,    16'd10,    32'sd77},         1'b1, '{4'd0,  1'b1, ST_BAD_FROM, 64'd0,  1'b0}},
        '{'{16'd10,    16'd0,     32'sd5},          1'b1, '{4'd0,  1'b1, ST_BAD_TO,   64'd0,  1'b0}},
        '{'{16'd10,    16'd1,     32'sd5},          1'b1, '{4'd0,  1'b1, ST_BAD_TO,   64'd0,  1'b0}},
        '{'{16'd10,    16'd17,    32'sd5},          1'b1, '{4'd0,  1'b1, ST_BAD_TO,   64'd0,  1'b0}},
        '{'{16'd10,    16'hFFFF,  -32'sd5},         1'b1, '{4'd0,  1'b1, ST_BAD_TO,   64'd0,  1'b0}},
        '{'{16'd10,    16'd10,    32'sd0},          1'b1, '{4'd0,  1'b1, ST_NONPOS,   64'd0,  1'b0}},
        '{'{16'd10,    16'd10,    32'h80000000},    1'b1, '{4'd0,  1'b1, ST_NONPOS,   64'd0,  1'b0}},
        '{'{16'd10,    16'd16,    -32'sd1},         1'b1, '{4'd0,  1'b1, ST_NONPOS,   64'd0,  1'b0}},
        '{'{16'd10,    16'd2,     32'sd1},          1'b1, '{4'd1,  1'b1, ST_OK,       64'd1,  1'b0}},
        '{'{16'd10,    16'd16,    32'sd15},         1'b1, '{4'd15, 1'b1, ST_OK,       64'd15, 1'b0}},
        '{'{16'd10,    16'd16,    32'sd9},          1'b1, '{4'd9,  1'b1, ST_OK,       64'd9,  1'b0}},
        '{'{16'd10,    16'd2,     32'h7FFFFFFF},    1'b0, '0},
        '{'{16'd10,    16'd16,    32'h7FFFFFFF},    1'b0, '0},
        '{'{16'd10,    16'd3,     32'h7FFFFFFF},    1'b0, '0},
        '{'{16'd10,    16'd10,    32'h7FFFFFFF},    1'b0, '0},
        '{'{16'd10,    16'd10,    32'sd1000000000}, 1'b0, '0},
        '{'{16'd10,    16'd2,     32'h40000000},    1'b0, '0},
        '{'{16'd10,    16'd7,     32'sd12345},      1'b0, '0},
        '{'{16'd10,    16'd15,    32'h7FFFFFFF},    1'b0, '0},
        '{'{16'd10,    16'd4,     32'sd1},          1'b0, '0},
        '{'{16'd10,    16'd2,     32'sd2},          1'b0, '0},
        '{'{16'd10,    16'd9,     32'h55555555},    1'b0, '0}
    };

    radix_digit_converter uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic void predict_conversion(input t_in it);
        logic [3:0]  digs [0:RDC_MAX_DIGITS-1];
        logic [31:0] rest;
        logic [31:0] base;
        logic [63:0] packed_acc;
        logic        sat;
        int          n;
        t_out        res;
        res      = '0;
        res.last = 1'b1;
        if (it.from_base != SRC_BASE) begin
            res.status = ST_BAD_FROM;
            pending_digits.push_back(res);
        end else if (it.to_base < MIN_BASE || it.to_base > 16'(RDC_MAX_BASE)) begin
            res.status = ST_BAD_TO;
            pending_digits.push_back(res);
        end else if (it.value[31] || it.value == 32'd0) begin
            res.status = ST_NONPOS;
            pending_digits.push_back(res);
        end else begin
            base       = {16'd0, it.to_base};
            rest       = it.value;
            n          = 0;
            packed_acc = 64'd0;
            sat        = 1'b0;
            while (rest != 32'd0 && n < RDC_MAX_DIGITS) begin
                digs[n] = 4'(rest % base);
                rest    = rest / base;
                n++;
            end
            for (int k = n - 1; k >= 0; k--) begin
                if (!sat) begin
                    if (packed_acc > (PACK_CAP - 64'(digs[k])) / 64'd10) begin
                        sat        = 1'b1;
                        packed_acc = PACK_CAP;
                    end else begin
                        packed_acc = packed_acc * 64'd10 + 64'(digs[k]);
                    end
                end
                res.digit           = digs[k];
                res.last            = (k == 0);
                res.status          = ST_OK;
                res.packed_value    = packed_acc;
                res.packed_overflow = sat;
                pending_digits.push_back(res);
            end
        end
    endfunction

    function automatic t_in random_item();
        t_in it;
        int  pick;
        int  width;
        pick         = $urandom_range(99);
        it.from_base = SRC_BASE;
        it.to_base   = 16'($urandom_range(2, RDC_MAX_BASE));
        width        = $urandom_range(1, 31);
        it.value     = $urandom & ((32'd1 << width) - 32'd1);
        if (it.value == 32'd0) begin
            it.value = 32'd1;
        end
        if (pick >= 75 && pick < 83) begin
            it.from_base = 16'($urandom);
            it.to_base   = 16'($urandom);
            it.value     = $urandom;
        end else if (pick >= 83 && pick < 91) begin
            case ($urandom_range(2))
                0: it.to_base = 16'($urandom_range(1));
                1: it.to_base = 16'($urandom_range(RDC_MAX_BASE + 1, 65535));
                default: it.to_base = 16'($urandom);
            endcase
            if ($urandom_range(1) == 0) begin
                it.value = $urandom;
            end
        end else if (pick >= 91) begin
            it.value = ($urandom_range(3) == 0) ? 32'd0 : ($urandom | 32'h80000000);
        end
        return it;
    endfunction

    // Each cycle in which the sender could offer an item is idle with the given chance.
    function automatic int idle_gap(input int pct);
        int gap;
        gap = 0;
        while ($urandom_range(99) < pct) begin
            gap++;
        end
        return gap;
    endfunction

    task automatic issue_item(input t_in it, input logic typed, input t_out want, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        if (typed) begin
            pending_digits.push_back(want);
        end else begin
            predict_conversion(it);
        end
    endtask

    task automatic drain_pending();
        start <= 1'b0;
        while (pending_digits.size() != 0) @(posedge i_clk);
    endtask

    task automatic report_field(input string fname, input logic [63:0] want,
                                input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_out want;
        if (i_rst_n && o_valid) begin
            if (pending_digits.size() == 0) begin
                $display("%0t: unexpected item, expected none, actual digit %0d packed %0d",
                         $time, o_result.digit, o_result.packed_value);
                mismatches++;
            end else begin
                want = pending_digits.pop_front();
                report_field("digit", 64'(want.digit), 64'(o_result.digit));
                report_field("last", 64'(want.last), 64'(o_result.last));
                report_field("status", 64'(want.status), 64'(o_result.status));
                report_field("packed_value", want.packed_value, o_result.packed_value);
                report_field("packed_overflow", 64'(want.packed_overflow),
                             64'(o_result.packed_overflow));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_item      = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++) begin
            issue_item(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].want, 0);
        end
        drain_pending();

        // The three random phases differ in how often the sender idles; the last also sends one more item.
        for (int i = 0; i < 115; i++) begin
            issue_item(random_item(), 1'b0, '0, idle_gap(31));
        end
        drain_pending();
        for (int i = 0; i < 115; i++) begin
            issue_item(random_item(), 1'b0, '0, idle_gap(57));
        end
        drain_pending();
        for (int i = 0; i < 116; i++) begin
            issue_item(random_item(), 1'b0, '0, 0);
        end
        drain_pending();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (pending_digits.size() != 0) begin
            $display("%0t: %0d items still expected", $time, pending_digits.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
